// ===== rtl/ldf_pkg.sv =====
package ldf_pkg;

    // Header is four bytes of little-endian total length, header included.
    localparam logic [2:0]  HDR_COUNT = 3'd4;
    localparam logic [2:0]  HDR_LAST  = 3'd3;
    localparam logic [31:0] HDR_LEN   = 32'd4;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_ZERO   = 2'd1,
        FAULT_SHORT  = 2'd2,
        FAULT_CLOSED = 2'd3
    } fault_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       link_closed;
    } ldf_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_good;
        logic        first_mark;
        logic        last_mark;
        logic [31:0] packet_length;
        fault_t      fault;
    } ldf_out_t;

endpackage

// ===== rtl/length_prefixed_deframer.sv =====
// Path: an item accepted on stream_* is written into the input register, moves into
// the result register once that is empty or being emptied, and is presented on frame_* from there.
// Throughput: one item per cycle while frame_stall is low, set by the combinational framing update
// between the input register and the result register.
// Reset: rst_n is asynchronous and active low; it empties both registers,
// clears the header and length counters and the failed state.
module length_prefixed_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              stream_valid,
    output logic              stream_stall,
    input  ldf_pkg::ldf_in_t  stream_item,
    output logic              frame_valid,
    input  logic              frame_stall,
    output ldf_pkg::ldf_out_t frame_item
);
    import ldf_pkg::*;

    // Input register: holds one accepted byte until the framing logic
    // can move it into the result register.
    logic     in_valid_reg, in_valid_next;
    ldf_in_t  in_item_reg;

    // Result register: holds the finished item until downstream takes it.
    logic     out_valid_reg, out_valid_next;
    ldf_out_t out_item_reg;

    ldf_out_t result;
    logic     accept;
    logic     advance;

    // The byte in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle. The framing state is
    // updated in the same cycle, so every byte steps the state exactly once.
    assign advance      = in_valid_reg && (!out_valid_reg || !frame_stall);
    assign stream_stall = in_valid_reg && !advance;
    assign accept       = stream_valid && !stream_stall;

    ldf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!frame_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= stream_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame_item  = out_item_reg;

endmodule

// ===== rtl/ldf_core.sv =====
module ldf_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ldf_pkg::ldf_in_t item,
    output ldf_pkg::ldf_out_t result
);
    import ldf_pkg::*;

    logic [23:0] header_bytes_reg, header_bytes_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] packet_total_reg, packet_total_next;
    logic        failed_reg, failed_next;

    logic [31:0] len;
    logic [31:0] left_dec;

    assign len      = {item.in_byte, header_bytes_reg};
    assign left_dec = bytes_left_reg - 32'd1;

    always_comb
    begin
        header_bytes_next = header_bytes_reg;
        header_count_next = header_count_reg;
        bytes_left_next   = bytes_left_reg;
        packet_total_next = packet_total_reg;
        failed_next       = failed_reg;

        result               = '0;
        result.out_byte      = item.link_closed ? 8'd0 : item.in_byte;
        result.fault         = FAULT_NONE;

        if (failed_reg)
        begin
            // A failed stream passes bytes through with no marks until reset.
        end
        else if (item.link_closed)
        begin
            result.fault = FAULT_CLOSED;
            failed_next  = 1'b1;
        end
        else if (header_count_reg < HDR_LAST)
        begin
            result.byte_good  = 1'b1;
            header_count_next = header_count_reg + 3'd1;
            case (header_count_reg[1:0])
                2'd0:
                begin
                    result.first_mark = 1'b1;
                    header_bytes_next = {16'd0, item.in_byte};
                end
                2'd1:    header_bytes_next[15:8]  = item.in_byte;
                default: header_bytes_next[23:16] = item.in_byte;
            endcase
        end
        else if (header_count_reg == HDR_LAST)
        begin
            if (len == 32'd0)
            begin
                result.fault = FAULT_ZERO;
                failed_next  = 1'b1;
            end
            else if (len < HDR_LEN)
            begin
                result.fault = FAULT_SHORT;
                failed_next  = 1'b1;
            end
            else if (len == HDR_LEN)
            begin
                result.byte_good     = 1'b1;
                result.last_mark     = 1'b1;
                result.packet_length = len;
                header_count_next    = 3'd0;
                header_bytes_next    = 24'd0;
            end
            else
            begin
                result.byte_good  = 1'b1;
                packet_total_next = len;
                bytes_left_next   = len - HDR_LEN;
                header_count_next = HDR_COUNT;
            end
        end
        else
        begin
            result.byte_good = 1'b1;
            bytes_left_next  = left_dec;
            if (left_dec == 32'd0)
            begin
                result.last_mark     = 1'b1;
                result.packet_length = packet_total_reg;
                header_count_next    = 3'd0;
                header_bytes_next    = 24'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg <= '0;
            header_count_reg <= '0;
            bytes_left_reg   <= '0;
            packet_total_reg <= '0;
            failed_reg       <= 1'b0;
        end
        else if (step)
        begin
            header_bytes_reg <= header_bytes_next;
            header_count_reg <= header_count_next;
            bytes_left_reg   <= bytes_left_next;
            packet_total_reg <= packet_total_next;
            failed_reg       <= failed_next;
        end
    end

endmodule

// ===== rtl/ldf_checker.sv =====
module ldf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              frame_valid,
    input logic              frame_stall,
    input ldf_pkg::ldf_out_t frame_item
);
    import ldf_pkg::*;

    logic seen_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_fault_reg <= 1'b0;
        end
        else if (frame_valid && !frame_stall && frame_item.fault != FAULT_NONE)
        begin
            seen_fault_reg <= 1'b1;
        end
    end

    // A faulting item is never a good packet byte.
    a_fault_not_good: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_item.fault != FAULT_NONE
        |-> !frame_item.byte_good && !frame_item.first_mark && !frame_item.last_mark)
        else $error("fault reported on a good byte");

    // A packet end carries a length of at least the header size.
    a_last_length: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_item.last_mark
        |-> frame_item.byte_good && frame_item.packet_length >= HDR_LEN)
        else $error("packet end with bad length");

    // The length is reported only on a packet end.
    a_length_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_item.last_mark |-> frame_item.packet_length == 32'd0)
        else $error("length reported off a packet end");

    // After a delivered fault the stream stays failed and silent.
    a_stays_failed: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && seen_fault_reg
        |-> !frame_item.byte_good && frame_item.fault == FAULT_NONE)
        else $error("activity after failure");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_stall |=> frame_valid && $stable(frame_item))
        else $error("stalled result changed");

endmodule

bind length_prefixed_deframer ldf_checker u_ldf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_item  (frame_item)
);
